[rtl/irtok_pkg.sv]
// Shared types and constants of the IR text tokenizer.
package irtok_pkg;

  localparam int unsigned POS_BITS   = 24;
  localparam int unsigned LINE_BITS  = 20;
  localparam int unsigned LEN_BITS   = 16;
  localparam int unsigned KIND_BITS  = 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [KIND_BITS-1:0] {
    TK_END    = 4'd0,
    TK_LOCAL  = 4'd1,
    TK_GLOBAL = 4'd2,
    TK_LPAREN = 4'd3,
    TK_RPAREN = 4'd4,
    TK_LBRACE = 4'd5,
    TK_RBRACE = 4'd6,
    TK_COLON  = 4'd7,
    TK_EQUALS = 4'd8,
    TK_IDENT  = 4'd9,
    TK_FUNC   = 4'd10,
    TK_KW_I   = 4'd11,
    TK_RET    = 4'd12,
    TK_INT    = 4'd13,
    TK_ERROR  = 4'd14
  } token_kind_e;

  typedef enum logic [2:0] {
    PM_NONE   = 3'd0,
    PM_LOCAL  = 3'd1,
    PM_GLOBAL = 3'd2,
    PM_IDENT  = 3'd3,
    PM_INT    = 3'd4
  } pend_mode_e;

  // Packed so that a plain cast gives the output tdata layout.
  typedef struct packed {
    logic [LINE_BITS-1:0] line;
    logic [LEN_BITS-1:0]  length;
    logic [POS_BITS-1:0]  start;
    token_kind_e          kind;
  } token_t;

  typedef struct packed {
    token_t first;
    token_t second;
    logic [1:0] count;
  } tok_pair_t;

  localparam logic [31:0] KW_FUNC = 32'h66756E63;
  localparam logic [31:0] KW_I    = 32'h00000069;
  localparam logic [31:0] KW_RET  = 32'h00726574;

endpackage

[rtl/irtok_core.sv]
// Tokenizer state and per-byte classification; produces up to two tokens per byte.
module irtok_core
  import irtok_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [7:0] byte_i,
  input  logic      step_i,
  output tok_pair_t pair_o
);

  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  pend_mode_e           mode_q, mode_d;
  logic [POS_BITS-1:0]  pstart_q, pstart_d;
  logic [LEN_BITS-1:0]  plen_q, plen_d;
  logic [LINE_BITS-1:0] pline_q, pline_d;
  logic [31:0]          lead_q, lead_d;

  logic        is_alpha, is_digit, is_space;
  logic        cont, flush;
  logic        own_vld;
  token_t      own_tok, pend_tok;
  token_kind_e own_kind, pend_kind;

  always_comb begin
    is_alpha = byte_i inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    is_digit = byte_i inside {[8'h30:8'h39]};
    is_space = byte_i inside {8'h20, [8'h09:8'h0D]};
    cont  = (mode_q != PM_NONE) &&
            ((mode_q == PM_INT) ? is_digit : (is_alpha || is_digit));
    flush = (mode_q != PM_NONE) && !cont;
  end

  always_comb begin
    case (mode_q)
      PM_LOCAL:  pend_kind = TK_LOCAL;
      PM_GLOBAL: pend_kind = TK_GLOBAL;
      PM_INT:    pend_kind = TK_INT;
      default: begin
        if (plen_q == LEN_BITS'(4) && lead_q == KW_FUNC) begin
          pend_kind = TK_FUNC;
        end else if (plen_q == LEN_BITS'(1) && lead_q == KW_I) begin
          pend_kind = TK_KW_I;
        end else if (plen_q == LEN_BITS'(3) && lead_q == KW_RET) begin
          pend_kind = TK_RET;
        end else begin
          pend_kind = TK_IDENT;
        end
      end
    endcase
    pend_tok.kind   = pend_kind;
    pend_tok.start  = pstart_q;
    pend_tok.length = plen_q;
    pend_tok.line   = pline_q;
  end

  always_comb begin
    own_vld  = 1'b1;
    own_kind = TK_ERROR;
    case (byte_i)
      8'h00: own_kind = TK_END;
      8'h28: own_kind = TK_LPAREN;
      8'h29: own_kind = TK_RPAREN;
      8'h7B: own_kind = TK_LBRACE;
      8'h7D: own_kind = TK_RBRACE;
      8'h3A: own_kind = TK_COLON;
      8'h3D: own_kind = TK_EQUALS;
      8'h25, 8'h40: own_vld = 1'b0;
      default: begin
        if (is_space || is_alpha || is_digit) begin
          own_vld = 1'b0;
        end
      end
    endcase
    own_tok.kind   = own_kind;
    own_tok.start  = pos_q;
    own_tok.length = (byte_i == 8'h00) ? '0 : LEN_BITS'(1);
    own_tok.line   = line_q;
  end

  always_comb begin
    pair_o.first  = flush ? pend_tok : own_tok;
    pair_o.second = own_tok;
    if (cont) begin
      pair_o.count = 2'd0;
    end else begin
      pair_o.count = {1'b0, flush} + {1'b0, own_vld};
    end
  end

  always_comb begin
    pos_d    = pos_q;
    line_d   = line_q;
    mode_d   = mode_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    pline_d  = pline_q;
    lead_d   = lead_q;
    if (step_i) begin
      if (cont) begin
        if (plen_q < LEN_BITS'(4)) begin
          lead_d = {lead_q[23:0], byte_i};
        end
        if (plen_q != '1) begin
          plen_d = plen_q + LEN_BITS'(1);
        end
        pos_d = pos_q + POS_BITS'(1);
      end else begin
        if (flush) begin
          mode_d = PM_NONE;
          plen_d = '0;
          lead_d = '0;
        end
        if (byte_i == 8'h00) begin
          pos_d    = '0;
          line_d   = LINE_BITS'(1);
          pstart_d = '0;
          pline_d  = LINE_BITS'(1);
        end else begin
          if (byte_i == 8'h25 || byte_i == 8'h40 || is_alpha || is_digit) begin
            if (byte_i == 8'h25) begin
              mode_d = PM_LOCAL;
            end else if (byte_i == 8'h40) begin
              mode_d = PM_GLOBAL;
            end else if (is_alpha) begin
              mode_d = PM_IDENT;
            end else begin
              mode_d = PM_INT;
            end
            pstart_d = pos_q;
            plen_d   = LEN_BITS'(1);
            pline_d  = line_q;
            lead_d   = {24'h0, byte_i};
          end
          if (byte_i == 8'h0A && line_q != '1) begin
            line_d = line_q + LINE_BITS'(1);
          end
          pos_d = pos_q + POS_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      line_q   <= LINE_BITS'(1);
      mode_q   <= PM_NONE;
      pstart_q <= '0;
      plen_q   <= '0;
      pline_q  <= LINE_BITS'(1);
      lead_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      line_q   <= line_d;
      mode_q   <= mode_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      pline_q  <= pline_d;
      lead_q   <= lead_d;
    end
  end

endmodule

[rtl/ir_text_tokenizer_unit.sv]
// Top level of the IR text tokenizer: input register, tokenizer core, result queue.
// The block takes one text byte per request, registers it, and tokenizes it from the
// input register once the queue has room, against the tracked offset, line and
// pending token. A byte yields zero, one or two tokens, which go into a four-entry
// queue drained one token per cycle on the master side while tready is high; tlast
// marks the last token caused by a byte. Input bytes are taken at one per clock
// while the queue has room for two more tokens, so the sustained rate is one byte
// per cycle, limited by back-pressure on tready and by the one-token-per-cycle
// output when bytes produce tokens faster than that. Byte zero ends the text: it
// flushes the pending token, emits an end token, and restarts offset and line counting.
module ir_text_tokenizer_unit
  import irtok_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [3:0] token_kind, [27:4] token_start,
                                      // [43:28] token_length, [63:44] token_line
  output logic        m_axis_tlast    // run_last
);

  typedef struct packed {
    token_t tok;
    logic   last;
  } entry_t;

  logic                in_vld_q;
  logic [7:0]          in_byte_q;
  logic                proc_fire;
  logic                pop;
  tok_pair_t           pair;
  entry_t              fifo_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] cnt_q;

  assign proc_fire     = in_vld_q && (cnt_q <= CNT_BITS'(FIFO_DEPTH - 2));
  assign s_axis_tready = !in_vld_q || proc_fire;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  irtok_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (in_byte_q),
    .step_i (proc_fire),
    .pair_o (pair)
  );

  // Push up to two tokens; the last one of the byte carries tlast.
  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      if (pair.count != 2'd0) begin
        fifo_q[wr_ptr_q] <= '{tok: pair.first, last: (pair.count == 2'd1)};
      end
      if (pair.count == 2'd2) begin
        fifo_q[wr_ptr_q + PTR_BITS'(1)] <= '{tok: pair.second, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (proc_fire) begin
        wr_ptr_q <= wr_ptr_q + PTR_BITS'(pair.count);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      end
      cnt_q <= cnt_q + (proc_fire ? CNT_BITS'(pair.count) : '0)
                     - CNT_BITS'(pop);
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q].tok;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

endmodule

[rtl/irtok_checker.sv]
// Port-level checks of the IR text tokenizer, bound to the top level.
module irtok_checker
  import irtok_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  token_t tok;
  assign tok = m_axis_tdata;

  // Hold a stalled output request.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  // Stall the input only while tokens wait at the output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending output");

  // End token has zero length and closes the run.
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && tok.kind == TK_END |-> m_axis_tlast && tok.length == '0)
    else $error("malformed end token");

  // Only a flushed pending token can precede another token of the same byte.
  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      tok.kind == TK_LOCAL || tok.kind == TK_GLOBAL || tok.kind == TK_IDENT ||
      tok.kind == TK_FUNC || tok.kind == TK_KW_I || tok.kind == TK_RET ||
      tok.kind == TK_INT)
    else $error("unexpected token before end of run");

  // Line numbers count from one.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> tok.line != '0)
    else $error("token on line zero");

endmodule

bind ir_text_tokenizer_unit irtok_checker u_irtok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
